### design/pstsc_pkg.sv
// ----------------------------------------------------------------------------
// pstsc_pkg
// Shared types and constants for the point set translate/scale block.
// ----------------------------------------------------------------------------
`default_nettype none
package pstsc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Z = 3'd6;

  localparam logic MODE_TRANSLATE = 1'b0;
  localparam logic MODE_SCALE     = 1'b1;

  localparam int unsigned SUM_W = 38;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_MUL,
    ST_EMIT_ADD,
    ST_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic load;      // store and accumulate the input point
    logic drop;      // mark dropped point
    logic div_start; // load divider
    logic div_step;  // one restoring step
    logic rd;        // read store at emit index
    logic mul;       // register products
    logic add;       // register sums
    logic emit;      // present result
    logic clear;     // end of run
  } cmd_t;

  typedef struct packed {
    logic full;
    logic div_done;
    logic emit_last;
    logic empty;
  } sts_t;

endpackage
`default_nettype wire

### design/pstsc_ctrl.sv
// ----------------------------------------------------------------------------
// pstsc_ctrl
// Sequencer: load, centroid divide in scale mode, emit stored points.
// ----------------------------------------------------------------------------
`default_nettype none
module pstsc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            last_point,
  input  wire logic            mode,
  input  var  pstsc_pkg::sts_t sts,
  output var  pstsc_pkg::cmd_t cmd,
  output logic                 busy
);

  pstsc_pkg::state_t state, state_next;
  logic take;

  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pstsc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pstsc_pkg::ST_LOAD: begin
        if (take && last_point) begin
          if (sts.empty && sts.full) state_next = pstsc_pkg::ST_LOAD;
          else if (mode == pstsc_pkg::MODE_SCALE) state_next = pstsc_pkg::ST_DIV;
          else state_next = pstsc_pkg::ST_EMIT_RD;
        end
      end
      pstsc_pkg::ST_DIV:      if (sts.div_done) state_next = pstsc_pkg::ST_EMIT_RD;
      pstsc_pkg::ST_EMIT_RD:  state_next = pstsc_pkg::ST_EMIT_MUL;
      pstsc_pkg::ST_EMIT_MUL: state_next = pstsc_pkg::ST_EMIT_ADD;
      pstsc_pkg::ST_EMIT_ADD: state_next = pstsc_pkg::ST_EMIT_OUT;
      pstsc_pkg::ST_EMIT_OUT: begin
        state_next = sts.emit_last ? pstsc_pkg::ST_LOAD : pstsc_pkg::ST_EMIT_RD;
      end
      default: state_next = pstsc_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      pstsc_pkg::ST_LOAD: begin
        busy          = 1'b0;
        cmd.load      = take && !sts.full;
        cmd.drop      = take && sts.full;
        cmd.div_start = take && last_point;
        cmd.clear     = take && last_point && sts.empty && sts.full;
      end
      pstsc_pkg::ST_DIV:      cmd.div_step = 1'b1;
      pstsc_pkg::ST_EMIT_RD:  cmd.rd = 1'b1;
      pstsc_pkg::ST_EMIT_MUL: cmd.mul = 1'b1;
      pstsc_pkg::ST_EMIT_ADD: cmd.add = 1'b1;
      pstsc_pkg::ST_EMIT_OUT: begin
        cmd.emit  = 1'b1;
        cmd.clear = sts.emit_last;
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && last_point && !(sts.empty && sts.full)) |=> busy)
    else $error("not busy after last point");
  a_emit_only_out: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> state == pstsc_pkg::ST_EMIT_OUT)
    else $error("emit outside output state");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load || cmd.drop) |-> !busy)
    else $error("load while busy");
`endif

endmodule
`default_nettype wire

### design/pstsc_dp.sv
// ----------------------------------------------------------------------------
// pstsc_dp
// Point stores, running sums, serial centroid divider and per-point math.
// ----------------------------------------------------------------------------
`default_nettype none
module pstsc_dp #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  var  pstsc_pkg::cmd_t    cmd,
  output var  pstsc_pkg::sts_t    sts,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_y,
  input  wire logic signed [31:0] coord_z,
  input  wire logic               mode,
  input  wire logic signed [31:0] offset_x,
  input  wire logic signed [31:0] offset_y,
  input  wire logic signed [31:0] offset_z,
  input  wire logic signed [23:0] factor_x,
  input  wire logic signed [23:0] factor_y,
  input  wire logic signed [23:0] factor_z,
  output logic                    strobe,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic                    last_out,
  output logic                    overflow
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = pstsc_pkg::SUM_W;
  localparam int unsigned DIV_STEPS = SW;
  localparam int unsigned DCW = $clog2(DIV_STEPS + 1);

  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] mem_z [MAX_POINTS];
  logic signed [31:0] rd_x, rd_y, rd_z;

  logic signed [SW-1:0] sum [3];
  logic [CW-1:0] point_count;
  logic [CW-1:0] emit_idx;
  logic dropped;

  // restoring divider, three axes in parallel on magnitudes
  logic [SW-1:0] quo [3];
  logic [SW-1:0] rem [3];
  logic          neg [3];
  logic [DCW-1:0] div_cnt;
  logic signed [SW-1:0] cen [3];

  logic signed [31:0] pnt [3];
  logic signed [23:0] fac [3];
  logic signed [31:0] off [3];
  logic signed [55:0] prod_p [3];
  logic signed [61:0] prod_c [3];
  logic signed [SW-1:0] cen_r [3];
  logic signed [31:0] pnt_r [3];
  logic signed [63:0] acc [3];

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign sts.full      = (point_count == CW'(MAX_POINTS));
  assign sts.empty     = (point_count == '0);
  assign sts.div_done  = (div_cnt == DCW'(DIV_STEPS));
  assign sts.emit_last = (emit_idx + 1'b1 == point_count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_x[point_count[AW-1:0]] <= coord_x;
      mem_y[point_count[AW-1:0]] <= coord_y;
      mem_z[point_count[AW-1:0]] <= coord_z;
    end
    if (cmd.rd) begin
      rd_x <= mem_x[emit_idx[AW-1:0]];
      rd_y <= mem_y[emit_idx[AW-1:0]];
      rd_z <= mem_z[emit_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int a = 0; a < 3; a++) sum[a] <= '0;
      point_count <= '0;
      dropped     <= 1'b0;
      emit_idx    <= '0;
    end else begin
      if (cmd.load) begin
        sum[0] <= sum[0] + SW'(coord_x);
        sum[1] <= sum[1] + SW'(coord_y);
        sum[2] <= sum[2] + SW'(coord_z);
        point_count <= point_count + 1'b1;
      end
      if (cmd.drop) dropped <= 1'b1;
      if (cmd.emit) emit_idx <= emit_idx + 1'b1;
    end
  end

  // the divider is armed through the div_arm register, so it starts on sums
  // that already hold the last point's own sample
  logic div_arm;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_arm <= 1'b0;
      div_cnt <= '0;
    end else begin
      div_arm <= cmd.div_start;
      if (cmd.div_start) div_cnt <= '0;
      else if (cmd.div_step && !div_arm && !sts.div_done) div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      logic [SW:0] trial;
      trial = {rem[a][SW-2:0], quo[a][SW-1]} - {1'b0, {(SW-CW){1'b0}}, point_count};
      if (div_arm) begin
        neg[a] <= sum[a][SW-1];
        quo[a] <= sum[a][SW-1] ? SW'(-sum[a]) : sum[a];
        rem[a] <= '0;
      end else if (cmd.div_step && !sts.div_done) begin
        if (!trial[SW]) begin
          rem[a] <= trial[SW-1:0];
          quo[a] <= {quo[a][SW-2:0], 1'b1};
        end else begin
          rem[a] <= {rem[a][SW-2:0], quo[a][SW-1]};
          quo[a] <= {quo[a][SW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) cen[a] = neg[a] ? SW'(-quo[a]) : quo[a];
  end

  assign pnt[0] = rd_x;
  assign pnt[1] = rd_y;
  assign pnt[2] = rd_z;
  assign fac[0] = factor_x;
  assign fac[1] = factor_y;
  assign fac[2] = factor_z;
  assign off[0] = offset_x;
  assign off[1] = offset_y;
  assign off[2] = offset_z;

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (cmd.mul) begin
        prod_p[a] <= pnt[a] * fac[a];
        prod_c[a] <= cen[a] * fac[a];
        cen_r[a]  <= cen[a];
        pnt_r[a]  <= pnt[a];
      end
      if (cmd.add) begin
        if (mode == pstsc_pkg::MODE_SCALE) begin
          acc[a] <= 64'(prod_p[a] >>> 16) + 64'(cen_r[a]) - 64'(prod_c[a] >>> 16);
        end else begin
          acc[a] <= 64'(pnt_r[a]) + 64'(off[a]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x    <= sat32(acc[0]);
      out_y    <= sat32(acc[1]);
      out_z    <= sat32(acc[2]);
      last_out <= sts.emit_last;
      overflow <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");
  a_no_load_full: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !sts.full)
    else $error("store write when full");
  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> emit_idx < point_count)
    else $error("emit index out of range");
`endif

endmodule
`default_nettype wire

### design/point_set_translate_scale_centroid.sv
// A run ends with the last point; translate mode then emits directly, scale mode
// first runs the 38-step serial centroid divider.
// Throughput: one point per cycle while loading; results leave one point at a time.
// busy is high from the last point until the final result appears on the outputs.
// Reset clears counts and sums and resets config; the receiver cannot stall.
// ----------------------------------------------------------------------------
// point_set_translate_scale_centroid
// Stores a point set, then translates it or scales it about its centroid.
// ----------------------------------------------------------------------------
`default_nettype none
module point_set_translate_scale_centroid #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [31:0]                    coord_x,
  input  wire logic signed [31:0]                    coord_y,
  input  wire logic signed [31:0]                    coord_z,
  input  wire logic                                  last_point,
  input  wire logic                                  cfg_we,
  input  wire logic [pstsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pstsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                       strobe,
  output logic signed [31:0]                         out_x,
  output logic signed [31:0]                         out_y,
  output logic signed [31:0]                         out_z,
  output logic                                       last_out,
  output logic                                       overflow
);

  logic               mode;
  logic signed [31:0] offset_x, offset_y, offset_z;
  logic signed [23:0] factor_x, factor_y, factor_z;
  pstsc_pkg::cmd_t    cmd;
  pstsc_pkg::sts_t    sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= pstsc_pkg::MODE_TRANSLATE;
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      factor_x <= 24'sd65536;
      factor_y <= 24'sd65536;
      factor_z <= 24'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pstsc_pkg::REG_MODE:     mode     <= cfg_data[0];
        pstsc_pkg::REG_OFFSET_X: offset_x <= cfg_data;
        pstsc_pkg::REG_OFFSET_Y: offset_y <= cfg_data;
        pstsc_pkg::REG_OFFSET_Z: offset_z <= cfg_data;
        pstsc_pkg::REG_FACTOR_X: factor_x <= cfg_data[23:0];
        pstsc_pkg::REG_FACTOR_Y: factor_y <= cfg_data[23:0];
        pstsc_pkg::REG_FACTOR_Z: factor_z <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  pstsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_point (last_point),
    .mode       (mode),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  pstsc_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .coord_z  (coord_z),
    .mode     (mode),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .offset_z (offset_z),
    .factor_x (factor_x),
    .factor_y (factor_y),
    .factor_z (factor_z),
    .strobe   (strobe),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .last_out (last_out),
    .overflow (overflow)
  );

endmodule
`default_nettype wire
